// File: hw/rtl/tcpf_pkg.sv
package tcpf_pkg;

  localparam int unsigned KEY_W     = 8;
  localparam int unsigned PAYLOAD_W = 16;
  localparam int unsigned ENTRY_W   = KEY_W + PAYLOAD_W;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned OCC_W     = 5;

  localparam logic [KEY_W-1:0] THRESHOLD_RESET = 8'd65;

  localparam logic KIND_ENQUEUE = 1'b0;
  localparam logic KIND_DEQUEUE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_ENQUEUED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DEQUEUED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                has_data;
    logic                is_priority;
    logic [OCC_W-1:0]    occupancy;
  } op_t;

endpackage

// File: hw/rtl/tcpf_in_if.sv
interface tcpf_in_if;
  import tcpf_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [KEY_W-1:0]     item_key;
  logic [PAYLOAD_W-1:0] item_payload;

  modport source (output valid, output kind, output item_key, output item_payload,
                  input ready);
  modport sink   (input valid, input kind, input item_key, input item_payload,
                  output ready);
endinterface

// File: hw/rtl/tcpf_out_if.sv
interface tcpf_out_if;
  import tcpf_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [KEY_W-1:0]     out_key;
  logic [PAYLOAD_W-1:0] out_payload;
  logic                 out_is_priority;
  logic [OCC_W-1:0]     occupancy;

  modport source (output valid, output status, output out_key, output out_payload,
                  output out_is_priority, output occupancy, input ready);
  modport sink   (input valid, input status, input out_key, input out_payload,
                  input out_is_priority, input occupancy, output ready);
endinterface

// File: hw/rtl/two_class_priority_fifo_core.sv
// Two-class FIFO: each enqueue item whose key is strictly above the threshold
// register joins the priority class, any other joins the normal class, and a
// dequeue item takes the oldest priority entry, else the oldest normal entry.
// Each class lives in its own DEPTH-entry RAM; total occupancy is capped at
// DEPTH, and every item yields exactly one result item carrying a status
// (enqueued, dequeued, rejected because full, dequeue on empty). An item
// is accepted in ST_IDLE, where it issues the RAM write or read and updates
// the pointers; ST_RESULT then captures the registered RAM read into the
// output register once that register is free. No item is accepted in
// ST_RESULT; the next item is accepted while a result still waits. The
// threshold resets to 65 and is meant to change only while the queue is empty.
module two_class_priority_fifo_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tcpf_pkg::KEY_W-1:0] cfg_wdata_i,
  tcpf_in_if.sink                    in_if,
  tcpf_out_if.source                 out_if
);
  import tcpf_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RESULT
  } state_e;

  state_e               state_q;
  logic [KEY_W-1:0]     threshold_q;
  logic                 out_valid_q;
  logic [STATUS_W-1:0]  status_q;
  logic [KEY_W-1:0]     out_key_q;
  logic [PAYLOAD_W-1:0] out_payload_q;
  logic                 out_prio_q;
  logic [OCC_W-1:0]     occupancy_q;

  logic                 start;
  logic                 out_free;
  op_t                  op;
  logic [KEY_W-1:0]     rd_key;
  logic [PAYLOAD_W-1:0] rd_payload;

  assign in_if.ready = (state_q == ST_IDLE);
  assign start       = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_q || out_if.ready;

  tcpf_engine #(
    .DEPTH(DEPTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .kind_i      (in_if.kind),
    .key_i       (in_if.item_key),
    .payload_i   (in_if.item_payload),
    .threshold_i (threshold_q),
    .op_o        (op),
    .rd_key_o    (rd_key),
    .rd_payload_o(rd_payload)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      threshold_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_valid_q   <= 1'b0;
      status_q      <= '0;
      out_key_q     <= '0;
      out_payload_q <= '0;
      out_prio_q    <= 1'b0;
      occupancy_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (out_if.ready) begin
            out_valid_q <= 1'b0;
          end
          if (start) begin
            state_q <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            status_q      <= op.status;
            out_key_q     <= op.has_data ? rd_key : '0;
            out_payload_q <= op.has_data ? rd_payload : '0;
            out_prio_q    <= op.is_priority;
            occupancy_q   <= op.occupancy;
            state_q       <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_if.valid           = out_valid_q;
  assign out_if.status          = status_q;
  assign out_if.out_key         = out_key_q;
  assign out_if.out_payload     = out_payload_q;
  assign out_if.out_is_priority = out_prio_q;
  assign out_if.occupancy       = occupancy_q;

endmodule

// File: hw/rtl/tcpf_ram.sv
module tcpf_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/tcpf_engine.sv
module tcpf_engine #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           kind_i,
  input  logic [tcpf_pkg::KEY_W-1:0]     key_i,
  input  logic [tcpf_pkg::PAYLOAD_W-1:0] payload_i,
  input  logic [tcpf_pkg::KEY_W-1:0]     threshold_i,
  output tcpf_pkg::op_t                  op_o,
  output logic [tcpf_pkg::KEY_W-1:0]     rd_key_o,
  output logic [tcpf_pkg::PAYLOAD_W-1:0] rd_payload_o
);
  import tcpf_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned TW = CW + 1;

  function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] ptr);
    next_ptr = (ptr == AW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  logic [AW-1:0] p_head_q, p_head_d, p_tail_q, p_tail_d;
  logic [AW-1:0] n_head_q, n_head_d, n_tail_q, n_tail_d;
  logic [CW-1:0] p_cnt_q, p_cnt_d, n_cnt_q, n_cnt_d;
  op_t           op_q, op_d;

  logic [TW-1:0]       total;
  logic [TW-1:0]       total_next;
  logic [TW+OCC_W-1:0] total_ext;
  logic                full;
  logic                enq, p_wr, n_wr, deq, p_rd, n_rd;
  logic [ENTRY_W-1:0]  wr_word, p_rdata, n_rdata, rd_word;

  assign total   = TW'(p_cnt_q) + TW'(n_cnt_q);
  assign full    = (total >= TW'(DEPTH));
  assign enq     = start_i && (kind_i == KIND_ENQUEUE) && !full;
  assign p_wr    = enq && (key_i > threshold_i);
  assign n_wr    = enq && !(key_i > threshold_i);
  assign deq     = start_i && (kind_i == KIND_DEQUEUE);
  assign p_rd    = deq && (p_cnt_q != '0);
  assign n_rd    = deq && (p_cnt_q == '0) && (n_cnt_q != '0);
  assign wr_word = {key_i, payload_i};

  always_comb begin
    p_head_d = p_rd ? next_ptr(p_head_q) : p_head_q;
    n_head_d = n_rd ? next_ptr(n_head_q) : n_head_q;
    p_tail_d = p_wr ? next_ptr(p_tail_q) : p_tail_q;
    n_tail_d = n_wr ? next_ptr(n_tail_q) : n_tail_q;
    p_cnt_d  = p_cnt_q;
    n_cnt_d  = n_cnt_q;
    if (p_wr) begin
      p_cnt_d = p_cnt_q + 1'b1;
    end else if (p_rd) begin
      p_cnt_d = p_cnt_q - 1'b1;
    end
    if (n_wr) begin
      n_cnt_d = n_cnt_q + 1'b1;
    end else if (n_rd) begin
      n_cnt_d = n_cnt_q - 1'b1;
    end

    if (enq) begin
      total_next = total + 1'b1;
    end else if (p_rd || n_rd) begin
      total_next = total - 1'b1;
    end else begin
      total_next = total;
    end
    total_ext = {{OCC_W{1'b0}}, total_next};

    op_d.has_data    = p_rd || n_rd;
    op_d.is_priority = p_rd;
    op_d.occupancy   = total_ext[OCC_W-1:0];
    if (kind_i == KIND_ENQUEUE) begin
      op_d.status = full ? STATUS_FULL : STATUS_ENQUEUED;
    end else begin
      op_d.status = (p_rd || n_rd) ? STATUS_DEQUEUED : STATUS_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_head_q <= '0;
      p_tail_q <= '0;
      n_head_q <= '0;
      n_tail_q <= '0;
      p_cnt_q  <= '0;
      n_cnt_q  <= '0;
      op_q     <= '0;
    end else if (start_i) begin
      p_head_q <= p_head_d;
      p_tail_q <= p_tail_d;
      n_head_q <= n_head_d;
      n_tail_q <= n_tail_d;
      p_cnt_q  <= p_cnt_d;
      n_cnt_q  <= n_cnt_d;
      op_q     <= op_d;
    end
  end

  tcpf_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_prio_ram (
    .clk_i  (clk_i),
    .we_i   (p_wr),
    .waddr_i(p_tail_q),
    .wdata_i(wr_word),
    .re_i   (p_rd),
    .raddr_i(p_head_q),
    .rdata_o(p_rdata)
  );

  tcpf_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_norm_ram (
    .clk_i  (clk_i),
    .we_i   (n_wr),
    .waddr_i(n_tail_q),
    .wdata_i(wr_word),
    .re_i   (n_rd),
    .raddr_i(n_head_q),
    .rdata_o(n_rdata)
  );

  assign rd_word      = op_q.is_priority ? p_rdata : n_rdata;
  assign rd_key_o     = rd_word[ENTRY_W-1:PAYLOAD_W];
  assign rd_payload_o = rd_word[PAYLOAD_W-1:0];
  assign op_o         = op_q;

endmodule
